// ----- sv/wthd_pkg.sv -----
// Package: shared types, constants and helpers for the word dedup block
`timescale 1ns / 1ps
package wthd_pkg;
    localparam int MAX_WORD_DEF = 29;
    localparam int BUCKETS_DEF = 1024;
    localparam int WAYS_DEF = 4;
    localparam logic [4:0] MAX_LEN_RESET = 5'd29;
    localparam logic [63:0] HASH_SEED = 64'd5381;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_file;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
        logic       set_full;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_EMIT
    } t_back_state;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122);
    endfunction
endpackage

// ----- sv/wthd_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module wthd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/wthd_front.sv -----
// Front end: gathers bytes into words and hashes them, hands closed words on
`timescale 1ns / 1ps
module wthd_front #(
    parameter int MAX_WORD = wthd_pkg::MAX_WORD_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [4:0]              i_max_len,
    input  logic                    i_valid,
    input  wthd_pkg::t_in_beat      i_beat,
    output logic                    o_ready,
    output logic                    o_word_valid,
    output logic [MAX_WORD*8-1:0]   o_word,
    output logic [5:0]              o_word_len,
    output logic [63:0]             o_word_hash,
    input  logic                    i_word_ready
);
    logic [MAX_WORD*8-1:0] r_buf, n_buf;
    logic [5:0]            r_len, n_len;
    logic [63:0]           r_hash, n_hash;
    logic                  r_ovalid, n_ovalid;
    logic [MAX_WORD*8-1:0] r_oword, n_oword;
    logic [5:0]            r_olen, n_olen;
    logic [63:0]           r_ohash, n_ohash;
    logic [5:0]            limit;
    logic                  alnum, close, take;
    logic [MAX_WORD*8-1:0] app_buf;
    logic [5:0]            app_len;
    logic [63:0]           app_hash;

    always_comb begin
        limit = {1'b0, i_max_len};
        if (limit == 6'd0) limit = 6'd1;
        if (limit > 6'(MAX_WORD)) limit = 6'(MAX_WORD);
    end

    assign o_ready = !r_ovalid || i_word_ready;
    assign take = i_valid && o_ready;
    assign alnum = wthd_pkg::is_alnum(i_beat.char_code);

    always_comb begin
        app_buf = r_buf;
        app_len = r_len;
        app_hash = r_hash;
        if (alnum && r_len < 6'(MAX_WORD)) begin
            app_buf[r_len*8 +: 8] = i_beat.char_code;
            app_len = r_len + 6'd1;
            app_hash = ((r_hash << 5) + r_hash) ^ {56'd0, i_beat.char_code};
        end
        close = (alnum ? (app_len >= limit || i_beat.end_of_file) : 1'b1)
                && app_len != 6'd0;
    end

    always_comb begin
        n_buf = r_buf;
        n_len = r_len;
        n_hash = r_hash;
        n_ovalid = r_ovalid && !i_word_ready;
        n_oword = r_oword;
        n_olen = r_olen;
        n_ohash = r_ohash;
        if (take) begin
            if (close) begin
                n_ovalid = 1'b1;
                n_oword = app_buf;
                for (int i = 0; i < MAX_WORD; i++) begin
                    if (6'(i) >= app_len) n_oword[i*8 +: 8] = 8'd0;
                end
                n_olen = app_len;
                n_ohash = app_hash;
                n_len = 6'd0;
                n_hash = wthd_pkg::HASH_SEED;
            end else begin
                n_buf = app_buf;
                n_len = app_len;
                n_hash = app_hash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 6'd0;
            r_hash <= wthd_pkg::HASH_SEED;
            r_ovalid <= 1'b0;
        end else begin
            r_len <= n_len;
            r_hash <= n_hash;
            r_ovalid <= n_ovalid;
        end
        r_buf <= n_buf;
        r_oword <= n_oword;
        r_olen <= n_olen;
        r_ohash <= n_ohash;
    end

    assign o_word_valid = r_ovalid;
    assign o_word = r_oword;
    assign o_word_len = r_olen;
    assign o_word_hash = r_ohash;
endmodule

// ----- sv/wthd_back.sv -----
// Back end: bucket lookup, insert and byte-by-byte emission of new words
`timescale 1ns / 1ps
module wthd_back #(
    parameter int MAX_WORD = wthd_pkg::MAX_WORD_DEF,
    parameter int BUCKETS = wthd_pkg::BUCKETS_DEF,
    parameter int WAYS = wthd_pkg::WAYS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_word_valid,
    input  logic [MAX_WORD*8-1:0] i_word,
    input  logic [5:0]            i_word_len,
    input  logic [63:0]           i_word_hash,
    output logic                  o_word_ready,
    output logic                  o_valid,
    output wthd_pkg::t_out_beat   o_beat,
    input  logic                  i_ready
);
    localparam int BW = $clog2(BUCKETS);
    localparam int EW = MAX_WORD * 8 + 6;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    wthd_pkg::t_back_state r_state, n_state;
    logic [BW-1:0]         r_clr, n_clr;
    logic [MAX_WORD*8-1:0] r_word, n_word;
    logic [5:0]            r_len, n_len;
    logic [BW-1:0]         r_bkt, n_bkt;
    logic [5:0]            r_idx, n_idx;
    logic                  r_full, n_full;

    logic [WAYS-1:0]       vld_rd;
    logic [WAYS-1:0]       vld_wdata;
    logic                  vld_we;
    logic [BW-1:0]         vld_waddr, vld_raddr;
    logic [EW-1:0]         ent_rd [WAYS];
    logic [WAYS-1:0]       ent_we;
    logic                  hit, has_free;
    logic [WW-1:0]         free_way;

    wthd_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid (
        .i_clk(i_clk), .i_we(vld_we), .i_waddr(vld_waddr), .i_wdata(vld_wdata),
        .i_raddr(vld_raddr), .o_rdata(vld_rd)
    );

    for (genvar g = 0; g < WAYS; g++) begin : g_way
        wthd_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_ent (
            .i_clk(i_clk), .i_we(ent_we[g]), .i_waddr(r_bkt),
            .i_wdata({r_len, r_word}), .i_raddr(vld_raddr), .o_rdata(ent_rd[g])
        );
    end

    assign vld_raddr = i_word_hash[BW-1:0];

    always_comb begin
        hit = 1'b0;
        has_free = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vld_rd[w]) begin
                if (ent_rd[w] == {r_len, r_word}) hit = 1'b1;
            end else begin
                has_free = 1'b1;
                free_way = WW'(w);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wthd_pkg::ST_CLEAR: if (r_clr == BW'(BUCKETS - 1)) n_state = wthd_pkg::ST_IDLE;
            wthd_pkg::ST_IDLE:  if (i_word_valid) n_state = wthd_pkg::ST_CMP;
            wthd_pkg::ST_READ:  n_state = wthd_pkg::ST_CMP;
            wthd_pkg::ST_CMP:   n_state = hit ? wthd_pkg::ST_IDLE : wthd_pkg::ST_EMIT;
            wthd_pkg::ST_EMIT: begin
                if (i_ready && r_idx + 6'd1 == r_len) n_state = wthd_pkg::ST_IDLE;
            end
            default: n_state = wthd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr + BW'(1);
        n_word = r_word;
        n_len = r_len;
        n_bkt = r_bkt;
        n_idx = r_idx;
        n_full = r_full;
        o_word_ready = 1'b0;
        vld_we = 1'b0;
        vld_waddr = r_bkt;
        vld_wdata = vld_rd;
        ent_we = '0;
        o_valid = 1'b0;
        case (r_state)
            wthd_pkg::ST_CLEAR: begin
                vld_we = 1'b1;
                vld_waddr = r_clr;
                vld_wdata = '0;
            end
            wthd_pkg::ST_IDLE: begin
                o_word_ready = 1'b1;
                n_word = i_word;
                n_len = i_word_len;
                n_bkt = i_word_hash[BW-1:0];
                n_idx = 6'd0;
            end
            wthd_pkg::ST_CMP: begin
                n_full = !has_free;
                if (!hit && has_free) begin
                    vld_we = 1'b1;
                    vld_wdata = vld_rd | (WAYS'(1) << free_way);
                    ent_we = WAYS'(1) << free_way;
                end
            end
            wthd_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) n_idx = r_idx + 6'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wthd_pkg::ST_CLEAR;
            r_clr <= '0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
        end
        r_word <= n_word;
        r_len <= n_len;
        r_bkt <= n_bkt;
        r_idx <= n_idx;
        r_full <= n_full;
    end

    assign o_beat.out_char = r_word[r_idx*8 +: 8];
    assign o_beat.last_char = (r_idx + 6'd1 == r_len);
    assign o_beat.set_full = r_full;
endmodule

// ----- sv/word_tokenize_hash_dedup.sv -----
// Top level: word tokenizer with hashed set de-duplication
// channel | dir | handshake      | payload
// input   | in  | i_push/o_full  | i_in  (char_code, end_of_file)
// result  | out | o_empty/i_pop  | o_out (out_char, last_char, set_full)
// config  | in  | i_cfg_we       | i_cfg_data (max_word_len)
// The front handles each byte as it is taken; a closed word waits in a one-deep stage.
// The back looks each word up in the bucket RAMs, then emits a new word byte by byte;
// it takes no new word until the last byte is out. After reset a clearing pass empties
// every bucket of the valid RAM; input stalls only once the word stage is occupied.
`timescale 1ns / 1ps
module word_tokenize_hash_dedup #(
    parameter int MAX_WORD = wthd_pkg::MAX_WORD_DEF,
    parameter int BUCKETS = wthd_pkg::BUCKETS_DEF,
    parameter int WAYS = wthd_pkg::WAYS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  wthd_pkg::t_in_beat  i_in,
    output logic                o_empty,
    input  logic                i_pop,
    output wthd_pkg::t_out_beat o_out,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_data
);
    logic [4:0]            r_max_len;
    logic                  ready, wvalid, wready, ovalid;
    logic [MAX_WORD*8-1:0] word;
    logic [5:0]            wlen;
    logic [63:0]           whash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= wthd_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    wthd_front #(.MAX_WORD(MAX_WORD)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_len(r_max_len),
        .i_valid(i_push), .i_beat(i_in), .o_ready(ready),
        .o_word_valid(wvalid), .o_word(word), .o_word_len(wlen),
        .o_word_hash(whash), .i_word_ready(wready)
    );

    wthd_back #(.MAX_WORD(MAX_WORD), .BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word_valid(wvalid), .i_word(word),
        .i_word_len(wlen), .i_word_hash(whash), .o_word_ready(wready),
        .o_valid(ovalid), .o_beat(o_out), .i_ready(i_pop)
    );

    assign o_full = !ready;
    assign o_empty = !ovalid;
endmodule

// ----- sv/wthd_checker.sv -----
// Port-level checker for the word dedup block, bound to the top level
`timescale 1ns / 1ps
module wthd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_empty,
    input logic                i_pop,
    input wthd_pkg::t_out_beat o_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_out))
        else $error("result beat changed while stalled");
    a_word_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && i_pop && !o_out.last_char |=> !o_empty)
        else $error("word broken before last beat");
    a_full_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && i_pop && !o_out.last_char |=> o_out.set_full == $past(o_out.set_full))
        else $error("set_full changed inside a word");
endmodule

bind word_tokenize_hash_dedup wthd_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_empty(o_empty), .i_pop(i_pop), .o_out(o_out)
);

// ----- verif/tb.sv -----
// Testbench: word tokenizer and hashed de-duplication checked against a built-in predictor
`timescale 1ns / 1ps
module tb;
    localparam int NB = 1024;
    localparam int NW = 4;
    localparam int MW = 29;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_push;
    logic      o_full;
    wthd_pkg::t_in_beat  i_in;
    logic      o_empty;
    logic      i_pop;
    wthd_pkg::t_out_beat o_out;
    logic      i_cfg_we;
    logic [4:0] i_cfg_data;

    word_tokenize_hash_dedup u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_in(i_in), .o_empty(o_empty), .i_pop(i_pop), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [7:0]  cur_word [MW];
    int          cur_len;
    logic [63:0] cur_hash;
    logic [NW-1:0] bucket_valid [NB];
    int          bucket_len [NB*NW];
    logic [7:0]  bucket_text [NB*NW][MW];
    logic [4:0]  word_limit_reg;

    wthd_pkg::t_out_beat expected_beats[$];
    int errors;
    int sent_items;
    int checked_beats;
    int full_words;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #80ms;
        $display("tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic bit alnum_byte(input logic [7:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
               (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic void close_word_predict();
        int bkt;
        int free_way;
        int e;
        bit same;
        wthd_pkg::t_out_beat b;
        if (cur_len == 0) return;
        bkt = int'(cur_hash[9:0]);
        free_way = -1;
        for (int w = 0; w < NW; w++) begin
            e = bkt * NW + w;
            if (bucket_valid[bkt][w]) begin
                same = (bucket_len[e] == cur_len);
                for (int k = 0; k < cur_len; k++)
                    if (bucket_text[e][k] != cur_word[k]) same = 0;
                if (same) begin
                    cur_len = 0;
                    cur_hash = wthd_pkg::HASH_SEED;
                    return;
                end
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (free_way >= 0) begin
            e = bkt * NW + free_way;
            bucket_valid[bkt][free_way] = 1'b1;
            bucket_len[e] = cur_len;
            for (int k = 0; k < cur_len; k++) bucket_text[e][k] = cur_word[k];
        end else begin
            full_words++;
        end
        for (int k = 0; k < cur_len; k++) begin
            b.out_char = cur_word[k];
            b.last_char = (k == cur_len - 1);
            b.set_full = (free_way < 0);
            expected_beats.push_back(b);
        end
        cur_len = 0;
        cur_hash = wthd_pkg::HASH_SEED;
    endfunction

    function automatic void predict_byte(input wthd_pkg::t_in_beat it);
        int lim;
        lim = word_limit_reg;
        if (lim < 1) lim = 1;
        if (lim > MW) lim = MW;
        if (alnum_byte(it.char_code)) begin
            if (cur_len < MW) begin
                cur_word[cur_len] = it.char_code;
                cur_len++;
                cur_hash = (cur_hash * 64'd33) ^ {56'd0, it.char_code};
            end
            if (cur_len >= lim || it.end_of_file) close_word_predict();
        end else begin
            close_word_predict();
        end
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_in <= '{char_code: c, end_of_file: eof};
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predict_byte('{char_code: c, end_of_file: eof});
        sent_items++;
    endtask

    task automatic send_text(input string s, input logic eof_last);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], eof_last && (k == s.len() - 1));
    endtask

    task automatic drain_and_settle();
        int guard;
        guard = 0;
        i_push <= 1'b0;
        while (expected_beats.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_beats.size() != 0) begin
            $display("tb: done, errors");
            $finish;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_word_limit(input logic [4:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        word_limit_reg = v;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_cycles > 0) begin
            i_pop <= 1'b0;
            if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
        end else begin
            i_pop <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat char %0h", o_out.out_char));
            end else begin
                wthd_pkg::t_out_beat x;
                x = expected_beats.pop_front();
                if (o_out.out_char !== x.out_char)
                    report_mismatch($sformatf("out_char %0h exp %0h",
                                              o_out.out_char, x.out_char));
                if (o_out.last_char !== x.last_char)
                    report_mismatch($sformatf("last_char %0b exp %0b",
                                              o_out.last_char, x.last_char));
                if (o_out.set_full !== x.set_full)
                    report_mismatch($sformatf("set_full %0b exp %0b",
                                              o_out.set_full, x.set_full));
                checked_beats++;
            end
        end
    end

    function automatic logic [7:0] rand_alnum();
        case ($urandom_range(2))
            0: return 8'd48 + 8'($urandom_range(9));
            1: return 8'd65 + 8'($urandom_range(25));
            default: return 8'd97 + 8'($urandom_range(25));
        endcase
    endfunction

    function automatic logic [7:0] rand_sep();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (alnum_byte(c));
        return c;
    endfunction

    task automatic test_directed();
        send_text("0 9 A Z a z", 1'b0);
        send_byte(8'h2f, 1'b0);
        send_text("az09", 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h80, 1'b0);
        send_text("az09 ", 1'b0);
        send_byte(8'h3a, 1'b1);
        drain_and_settle();
    endtask

    task automatic test_split_limits();
        write_word_limit(5'd1);
        send_text("xy", 1'b1);
        drain_and_settle();
        write_word_limit(5'd0);
        send_text("Qq", 1'b0);
        send_byte(8'h20, 1'b0);
        drain_and_settle();
        write_word_limit(5'd31);
        send_text("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefg", 1'b0);
        send_byte(8'h00, 1'b0);
        drain_and_settle();
        write_word_limit(5'd3);
        send_text("mno", 1'b1);
        drain_and_settle();
        write_word_limit(5'd29);
    endtask

    task automatic test_bucket_full();
        // words hashing to one bucket: "w" + decimal number, searched by brute force
        logic [63:0] h;
        int hits;
        string s;
        hits = 0;
        for (int k = 0; k < 40000 && hits < 6; k++) begin
            s = $sformatf("w%0d", k);
            h = wthd_pkg::HASH_SEED;
            for (int j = 0; j < s.len(); j++) h = (h * 64'd33) ^ {56'd0, s[j]};
            if (h[9:0] == 10'd777) begin
                send_text(s, 1'b0);
                send_byte(8'h2c, 1'b0);
                hits++;
            end
        end
        drain_and_settle();
    endtask

    task automatic test_random(input int n, input int limit);
        int cnt;
        int wl;
        write_word_limit(5'(limit));
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(9) < 8) begin
                wl = ($urandom_range(9) == 0) ? $urandom_range(1, 33) : $urandom_range(1, 4);
                for (int k = 0; k < wl; k++) begin
                    send_byte(rand_alnum(), ($urandom_range(19) == 0));
                    cnt++;
                end
                send_byte(rand_sep(), 1'($urandom_range(1)));
            end else begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            cnt++;
        end
        drain_and_settle();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int k = 0; k < 60; k++) send_byte((k % 3 == 2) ? 8'h20 : rand_alnum(), 1'b0);
        send_byte(8'h20, 1'b0);
        drain_and_settle();
    endtask

    initial begin
        errors = 0;
        sent_items = 0;
        checked_beats = 0;
        full_words = 0;
        hold_cycles = 0;
        send_idle_pct = 18;
        recv_idle_pct = 55;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        cur_len = 0;
        cur_hash = wthd_pkg::HASH_SEED;
        word_limit_reg = wthd_pkg::MAX_LEN_RESET;
        for (int b = 0; b < NB; b++) bucket_valid[b] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_split_limits();
        test_bucket_full();
        test_random(110, 29);
        send_idle_pct = 55;
        recv_idle_pct = 18;
        test_random(110, 2);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(110, 7);

        $display("tb: %0d bytes sent, %0d beats checked, %0d bucket-full words",
                 sent_items, checked_beats, full_words);
        $display("tb: word limits 0,1,2,3,7,29,31 and a long output stall covered");
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
